[rtl/core/jsff_pkg.sv]
`timescale 1ns / 1ps

package jsff_pkg;

  // Default sizes of the scheduler
  localparam int unsigned MACHINES_DEF = 32;
  localparam int unsigned JOBS_DEF     = 32;
  localparam int unsigned STEPS_DEF    = 32;
  localparam int unsigned HORIZON_DEF  = 8192;

  // Fixed field widths of the item and result ports
  localparam int JOB_W  = 5;
  localparam int STEP_W = 5;
  localparam int MACH_W = 5;
  localparam int DUR_W  = 8;
  localparam int TIME_W = 13;

  // Occupancy words hold 64 slots; the scan looks at 8 slots per cycle
  localparam int WORD_BITS = 64;
  localparam int WORD_LW   = 6;
  localparam int CHUNK     = 8;
  localparam int CHUNK_IW  = 3;

  typedef logic [CHUNK-1:0] chunk_t;

  typedef struct packed {
    logic                hit;
    logic [CHUNK_IW-1:0] idx;
    logic [DUR_W-1:0]    run;
  } chunk_res_t;

endpackage

[rtl/core/jsff_chunk_scan.sv]
`timescale 1ns / 1ps

module jsff_chunk_scan (
  input  jsff_pkg::chunk_t              busy_i,
  input  jsff_pkg::chunk_t              en_i,
  input  logic [jsff_pkg::DUR_W-1:0]    run_i,
  input  logic [jsff_pkg::DUR_W-1:0]    dur_i,
  output jsff_pkg::chunk_res_t          res_o
);

  always_comb begin
    logic [jsff_pkg::DUR_W-1:0]    run_v;
    logic                          hit_v;
    logic [jsff_pkg::CHUNK_IW-1:0] idx_v;
    run_v = run_i;
    hit_v = 1'b0;
    idx_v = '0;
    for (int i = 0; i < jsff_pkg::CHUNK; i++) begin
      if (en_i[i] && !hit_v) begin
        // a busy slot breaks the run, a free one extends it
        run_v = busy_i[i] ? '0 : run_v + 1'b1;
        if (run_v == dur_i) begin
          hit_v = 1'b1;
          idx_v = jsff_pkg::CHUNK_IW'(i);
        end
      end
    end
    res_o.hit = hit_v;
    res_o.idx = idx_v;
    res_o.run = run_v;
  end

endmodule

[rtl/core/job_shop_first_fit_scheduler_unit.sv]
`timescale 1ns / 1ps

// Job-shop first-fit scheduler. A load (mode 0) writes one operation-table entry in the
// accept cycle if job and step are in range and gives no result; busy_o stays low. A
// schedule item (mode 1) gives one result, strobed on done_o for a single cycle, which
// the receiver must take as it comes. An item naming a job out of range answers in the
// cycle after acceptance. Otherwise the unit reads the job record and the operation
// entry, starts the scan, walks the machine's occupancy memory 8 slots per cycle from
// one past the job's last finish, and finally marks the run with a read-modify-write of
// each 64-slot word it touches. No step left, a machine out of range or no free run
// before the horizon sets overflow_o. After reset all MACHINES * ceil(HORIZON / 64)
// occupancy words (4096 by default) are cleared one word per cycle, busy_o held high.
module job_shop_first_fit_scheduler_unit #(
  parameter int unsigned MACHINES = jsff_pkg::MACHINES_DEF,
  parameter int unsigned JOBS     = jsff_pkg::JOBS_DEF,
  parameter int unsigned STEPS    = jsff_pkg::STEPS_DEF,
  parameter int unsigned HORIZON  = jsff_pkg::HORIZON_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [jsff_pkg::JOB_W-1:0]    job_i,
  input  logic [jsff_pkg::STEP_W-1:0]   step_i,
  input  logic [jsff_pkg::MACH_W-1:0]   machine_i,
  input  logic [jsff_pkg::DUR_W-1:0]    duration_i,
  output logic                          done_o,
  output logic [jsff_pkg::JOB_W-1:0]    job_out_o,
  output logic [jsff_pkg::TIME_W-1:0]   end_time_o,
  output logic [jsff_pkg::TIME_W-1:0]   makespan_o,
  output logic                          overflow_o
);

  localparam int WORDS     = (HORIZON + jsff_pkg::WORD_BITS - 1) / jsff_pkg::WORD_BITS;
  localparam int OCC_DEPTH = MACHINES * WORDS;
  localparam int OCC_AW    = (OCC_DEPTH > 1) ? $clog2(OCC_DEPTH) : 1;
  localparam int WI_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LF_W      = $clog2(HORIZON);
  localparam int SLOT_W    = LF_W + 1;
  localparam int NS_W      = $clog2(STEPS + 1);
  localparam int JA_W      = (JOBS > 1) ? $clog2(JOBS) : 1;
  localparam int OP_DEPTH  = JOBS * STEPS;
  localparam int OP_AW     = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
  localparam int OP_DW     = jsff_pkg::MACH_W + jsff_pkg::DUR_W;
  localparam int JM_W      = NS_W + LF_W;
  localparam int WB        = jsff_pkg::WORD_BITS;
  localparam int WLW       = jsff_pkg::WORD_LW;
  localparam int CIW       = jsff_pkg::CHUNK_IW;
  localparam int DW        = jsff_pkg::DUR_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_JOB,
    ST_OP,
    ST_ISSUE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR
  } state_e;

  // Memories
  logic [WB-1:0]    occ_mem [OCC_DEPTH];
  logic [OP_DW-1:0] op_mem  [OP_DEPTH];
  logic [JM_W-1:0]  jm_mem  [JOBS];

  logic [WB-1:0]    occ_rdata_q;
  logic [OP_DW-1:0] op_rdata_q;
  logic [JM_W-1:0]  jm_rdata_q;

  logic              occ_re, occ_we;
  logic [OCC_AW-1:0] occ_raddr, occ_waddr;
  logic [WB-1:0]     occ_wdata;
  logic              op_re, op_we;
  logic [OP_AW-1:0]  op_raddr, op_waddr;
  logic [OP_DW-1:0]  op_wdata;
  logic              jm_re, jm_we;
  logic [JA_W-1:0]   jm_raddr, jm_waddr;
  logic [JM_W-1:0]   jm_wdata;

  // Control and datapath registers
  state_e                       state_q, state_d;
  logic [OCC_AW-1:0]            clr_q, clr_d;
  logic [JOBS-1:0]              jvld_q, jvld_d;
  logic [jsff_pkg::JOB_W-1:0]   job_q, job_d;
  logic [NS_W-1:0]              ns_q, ns_d;
  logic [LF_W-1:0]              lf_q, lf_d;
  logic [DW-1:0]                dur_q, dur_d;
  logic [OCC_AW-1:0]            mbase_q, mbase_d;
  logic [SLOT_W-1:0]            pos_q, pos_d;
  logic [DW-1:0]                run_q, run_d;
  logic [LF_W-1:0]              end_q, end_d;
  logic [LF_W-1:0]              start_q, start_d;
  logic [WI_W-1:0]              markw_q, markw_d;
  logic [LF_W-1:0]              mksp_q, mksp_d;
  logic                         done_q, done_d;
  logic                         ovf_q, ovf_d;
  logic [jsff_pkg::TIME_W-1:0]  res_end_q, res_end_d;

  // Scan helpers
  logic [SLOT_W-1:0]     base;
  logic [SLOT_W-1:0]     pos_nx;
  jsff_pkg::chunk_t      chunk_busy;
  jsff_pkg::chunk_t      chunk_en;
  jsff_pkg::chunk_res_t  sres;
  logic [WI_W-1:0]       endw;
  logic [WI_W-1:0]       startw;
  logic [WLW-1:0]        mask_lo, mask_hi;
  logic [WB-1:0]         mark_mask;

  assign base       = {pos_q[SLOT_W-1:CIW], {CIW{1'b0}}};
  assign pos_nx     = base + SLOT_W'(jsff_pkg::CHUNK);
  assign chunk_busy = occ_rdata_q[{pos_q[WLW-1:CIW], {CIW{1'b0}}} +: jsff_pkg::CHUNK];

  always_comb begin
    for (int i = 0; i < jsff_pkg::CHUNK; i++) begin
      chunk_en[i] = (CIW'(i) >= pos_q[CIW-1:0]) && ((32'(base) + 32'(i)) < HORIZON);
    end
  end

  jsff_chunk_scan u_scan (
    .busy_i (chunk_busy),
    .en_i   (chunk_en),
    .run_i  (run_q),
    .dur_i  (dur_q),
    .res_o  (sres)
  );

  assign endw      = WI_W'(end_q >> WLW);
  assign startw    = WI_W'(start_q >> WLW);
  assign mask_lo   = (markw_q == startw) ? start_q[WLW-1:0] : '0;
  assign mask_hi   = (markw_q == endw) ? end_q[WLW-1:0] : {WLW{1'b1}};
  assign mark_mask = ({WB{1'b1}} << mask_lo) & ({WB{1'b1}} >> ({WLW{1'b1}} - mask_hi));

  always_comb begin
    logic            finish;
    logic            fin_ovf;
    logic            advance;
    logic [LF_W-1:0] new_lf;
    logic            vld;
    logic [NS_W-1:0] ns_v;
    logic [DW-1:0]   dur_v;
    logic [LF_W-1:0] start_v;

    state_d   = state_q;
    clr_d     = clr_q;
    jvld_d    = jvld_q;
    job_d     = job_q;
    ns_d      = ns_q;
    lf_d      = lf_q;
    dur_d     = dur_q;
    mbase_d   = mbase_q;
    pos_d     = pos_q;
    run_d     = run_q;
    end_d     = end_q;
    start_d   = start_q;
    markw_d   = markw_q;
    mksp_d    = mksp_q;
    done_d    = 1'b0;
    ovf_d     = ovf_q;
    res_end_d = res_end_q;

    occ_re    = 1'b0;
    occ_raddr = '0;
    occ_we    = 1'b0;
    occ_waddr = '0;
    occ_wdata = '0;
    op_re     = 1'b0;
    op_raddr  = '0;
    op_we     = 1'b0;
    op_waddr  = '0;
    op_wdata  = '0;
    jm_re     = 1'b0;
    jm_raddr  = '0;
    jm_we     = 1'b0;
    jm_waddr  = '0;
    jm_wdata  = '0;

    finish  = 1'b0;
    fin_ovf = 1'b0;
    advance = 1'b0;
    new_lf  = lf_q;
    vld     = jvld_q[JA_W'(job_q)];
    ns_v    = vld ? jm_rdata_q[LF_W +: NS_W] : '0;
    dur_v   = op_rdata_q[DW-1:0];
    start_v = LF_W'(32'(end_q) + 32'd1 - 32'(dur_q));

    unique case (state_q)
      ST_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == OCC_AW'(OCC_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          job_d = job_i;
          if (!mode_i) begin
            if ((32'(job_i) < JOBS) && (32'(step_i) < STEPS)) begin
              op_we    = 1'b1;
              op_waddr = OP_AW'(32'(job_i) * STEPS + 32'(step_i));
              op_wdata = {machine_i, duration_i};
            end
          end else if (32'(job_i) >= JOBS) begin
            finish  = 1'b1;
            fin_ovf = 1'b1;
          end else begin
            jm_re    = 1'b1;
            jm_raddr = JA_W'(job_i);
            state_d  = ST_JOB;
          end
        end
      end
      ST_JOB: begin
        ns_d = ns_v;
        lf_d = vld ? jm_rdata_q[LF_W-1:0] : '0;
        if (32'(ns_v) >= STEPS) begin
          finish  = 1'b1;
          fin_ovf = 1'b1;
        end else begin
          op_re    = 1'b1;
          op_raddr = OP_AW'(32'(job_q) * STEPS + 32'(ns_v));
          state_d  = ST_OP;
        end
      end
      ST_OP: begin
        dur_d = (dur_v == '0) ? DW'(1) : dur_v;
        if ((32'(op_rdata_q[DW +: jsff_pkg::MACH_W]) >= MACHINES) ||
            ((32'(lf_q) + 32'd1) >= HORIZON)) begin
          finish  = 1'b1;
          fin_ovf = 1'b1;
          advance = 1'b1;
        end else begin
          mbase_d = OCC_AW'(32'(op_rdata_q[DW +: jsff_pkg::MACH_W]) * WORDS);
          pos_d   = SLOT_W'(lf_q) + 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        occ_re    = 1'b1;
        occ_raddr = mbase_q + OCC_AW'(pos_q >> WLW);
        run_d     = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        run_d = sres.run;
        if (sres.hit) begin
          end_d   = LF_W'(base + SLOT_W'(sres.idx));
          state_d = ST_MARK_RD;
        end else if (32'(pos_nx) >= HORIZON) begin
          finish  = 1'b1;
          fin_ovf = 1'b1;
          advance = 1'b1;
        end else begin
          pos_d = pos_nx;
          // fetch the next word as this one runs out
          if (pos_nx[WLW-1:0] == '0) begin
            occ_re    = 1'b1;
            occ_raddr = mbase_q + OCC_AW'(pos_nx >> WLW);
          end
        end
      end
      ST_MARK_RD: begin
        start_d   = start_v;
        markw_d   = WI_W'(start_v >> WLW);
        occ_re    = 1'b1;
        occ_raddr = mbase_q + OCC_AW'(start_v >> WLW);
        state_d   = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        occ_we    = 1'b1;
        occ_waddr = mbase_q + OCC_AW'(markw_q);
        occ_wdata = occ_rdata_q | mark_mask;
        if (markw_q == endw) begin
          finish  = 1'b1;
          advance = 1'b1;
          new_lf  = end_q;
        end else begin
          markw_d   = markw_q + 1'b1;
          occ_re    = 1'b1;
          occ_raddr = mbase_q + OCC_AW'(markw_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      done_d    = 1'b1;
      ovf_d     = fin_ovf;
      res_end_d = fin_ovf ? '0 : jsff_pkg::TIME_W'(end_q);
      state_d   = ST_IDLE;
      if (!fin_ovf && (end_q > mksp_q)) begin
        mksp_d = end_q;
      end
      if (advance) begin
        jm_we                 = 1'b1;
        jm_waddr              = JA_W'(job_q);
        jm_wdata              = {NS_W'(ns_q + 1'b1), new_lf};
        jvld_d[JA_W'(job_q)]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      jvld_q    <= '0;
      job_q     <= '0;
      ns_q      <= '0;
      lf_q      <= '0;
      dur_q     <= '0;
      mbase_q   <= '0;
      pos_q     <= '0;
      run_q     <= '0;
      end_q     <= '0;
      start_q   <= '0;
      markw_q   <= '0;
      mksp_q    <= '0;
      done_q    <= 1'b0;
      ovf_q     <= 1'b0;
      res_end_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      jvld_q    <= jvld_d;
      job_q     <= job_d;
      ns_q      <= ns_d;
      lf_q      <= lf_d;
      dur_q     <= dur_d;
      mbase_q   <= mbase_d;
      pos_q     <= pos_d;
      run_q     <= run_d;
      end_q     <= end_d;
      start_q   <= start_d;
      markw_q   <= markw_d;
      mksp_q    <= mksp_d;
      done_q    <= done_d;
      ovf_q     <= ovf_d;
      res_end_q <= res_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_rdata_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      op_mem[op_waddr] <= op_wdata;
    end
    if (op_re) begin
      op_rdata_q <= op_mem[op_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (jm_we) begin
      jm_mem[jm_waddr] <= jm_wdata;
    end
    if (jm_re) begin
      jm_rdata_q <= jm_mem[jm_raddr];
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign job_out_o  = job_q;
  assign end_time_o = res_end_q;
  assign makespan_o = jsff_pkg::TIME_W'(mksp_q);
  assign overflow_o = ovf_q;

  a_ovf_no_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && ovf_q |-> res_end_q == '0)
    else $error("overflow beat carries a nonzero end time");

  a_mksp_cover : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !ovf_q |-> end_q <= mksp_q)
    else $error("makespan below the end time just placed");

  a_occ_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_we |-> (state_q == ST_CLEAR) || (state_q == ST_MARK_WR))
    else $error("occupancy written outside clear or mark");

  a_mark_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MARK_WR |-> (markw_q <= endw) && (markw_q >= startw))
    else $error("mark pointer left the placed run");

endmodule
